[hw/rtl/tcc_pkg.sv]
// Shared types and constants of the congestion window controller.
`timescale 1ns / 1ps
package tcc_pkg;

  // Event codes
  localparam logic [1:0] ACT_SEND    = 2'd0;
  localparam logic [1:0] ACT_ACK     = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam int ACT_W   = 2;
  localparam int SEQ_W   = 32;
  localparam int CNT_W   = 11;
  localparam int MS_W    = 16;
  localparam int RTTQ_W  = 24;
  localparam int DUP_W   = 3;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SSTHRESH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIMEOUT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_RTT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_DEV      = 3'd4;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] RST_SSTHRESH    = 11'd64;
  localparam logic [MS_W-1:0]  RST_MIN_TIMEOUT = 16'd500;
  localparam logic [DUP_W-1:0] RST_DUP_THR     = 3'd3;
  localparam logic [MS_W-1:0]  RST_RTT         = 16'd1000;
  localparam logic [MS_W-1:0]  RST_DEV         = 16'd50;

  localparam logic [CNT_W-1:0]  CNT_MAX   = 11'h7FF;
  localparam logic [CNT_W-1:0]  THR_MIN   = 11'd2;
  localparam logic [DUP_W-1:0]  DUP_MAX   = 3'd7;
  localparam logic [RTTQ_W-1:0] RTTQ_MAX  = 24'hFFFFFF;
  localparam logic [RTTQ_W-1:0] RTTQ_HALF = 24'h7FFFFF;
  localparam logic [MS_W-1:0]   MS_MAX    = 16'hFFFF;

  typedef struct packed {
    logic load_in;
    logic do_send;
    logic do_dup;
    logic do_timeout;
    logic do_ack;
    logic smp_est;
    logic smp_dev;
    logic ss_grow;
    logic div_step;
    logic ca_add;
    logic out_load;
  } tcc_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             new_ack;
    logic             sample_en;
    logic             slow_start;
    logic             div_last;
  } tcc_sts_t;

  typedef struct packed {
    logic [CNT_W-1:0] window_packets;
    logic [CNT_W-1:0] threshold_packets;
    logic [MS_W-1:0]  timeout_ms;
    logic             retransmit;
    logic             timer_restart;
    logic             send_allowed;
    logic             in_slow_start;
    logic [CNT_W-1:0] in_flight_count;
  } tcc_result_t;

endpackage

[hw/rtl/tcc_ifs.sv]
// Channel interfaces: event requests, results and configuration writes.
`timescale 1ns / 1ps
interface tcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] ack_number;
  logic [31:0] expected_ack;
  logic [10:0] segments_covered;
  logic [15:0] sample_rtt_ms;
  modport source (output valid, action, ack_number, expected_ack, segments_covered,
                  sample_rtt_ms, input ready);
  modport sink (input valid, action, ack_number, expected_ack, segments_covered,
                sample_rtt_ms, output ready);
endinterface

interface tcc_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] window_packets;
  logic [10:0] threshold_packets;
  logic [15:0] timeout_ms;
  logic        retransmit;
  logic        timer_restart;
  logic        send_allowed;
  logic        in_slow_start;
  logic [10:0] in_flight_count;
  modport source (output valid, window_packets, threshold_packets, timeout_ms, retransmit,
                  timer_restart, send_allowed, in_slow_start, in_flight_count,
                  input ready);
  modport sink (input valid, window_packets, threshold_packets, timeout_ms, retransmit,
                timer_restart, send_allowed, in_slow_start, in_flight_count,
                output ready);
endinterface

interface tcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/tcc_ctrl.sv]
// Sequencer for the congestion window controller: steps the datapath per request.
`timescale 1ns / 1ps
module tcc_ctrl
  import tcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  tcc_sts_t sts,
  output tcc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_SMP_EST = 3'd2;
  localparam logic [2:0] S_SMP_DEV = 3'd3;
  localparam logic [2:0] S_SS_GROW = 3'd4;
  localparam logic [2:0] S_DIV     = 3'd5;
  localparam logic [2:0] S_CA_ADD  = 3'd6;
  localparam logic [2:0] S_FINISH  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.action)
          ACT_SEND: begin
            cmd.do_send = 1'b1;
            state_nxt   = S_FINISH;
          end
          ACT_TIMEOUT: begin
            cmd.do_timeout = 1'b1;
            state_nxt      = S_FINISH;
          end
          ACT_ACK: begin
            if (sts.new_ack) begin
              cmd.do_ack = 1'b1;
              if (sts.sample_en) state_nxt = S_SMP_EST;
              else if (sts.slow_start) state_nxt = S_SS_GROW;
              else state_nxt = S_DIV;
            end else begin
              cmd.do_dup = 1'b1;
              state_nxt  = S_FINISH;
            end
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_SMP_EST: begin
        cmd.smp_est = 1'b1;
        state_nxt   = S_SMP_DEV;
      end
      S_SMP_DEV: begin
        cmd.smp_dev = 1'b1;
        state_nxt   = sts.slow_start ? S_SS_GROW : S_DIV;
      end
      S_SS_GROW: begin
        cmd.ss_grow = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_CA_ADD;
      end
      S_CA_ADD: begin
        cmd.ca_add = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hw/rtl/tcc_dp.sv]
// Datapath: window, threshold, RTT estimators, serial divider and result register.
`timescale 1ns / 1ps
module tcc_dp
  import tcc_pkg::*;
#(
  parameter int MAX_WINDOW       = 1024,
  parameter int WINDOW_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcc_cmd_t              cmd,
  output tcc_sts_t              sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ACT_W-1:0]      in_action,
  input  logic [SEQ_W-1:0]      in_ack_number,
  input  logic [SEQ_W-1:0]      in_expected_ack,
  input  logic [CNT_W-1:0]      in_segments_covered,
  input  logic [MS_W-1:0]       in_sample_rtt_ms,
  output tcc_result_t           result
);

  localparam int F     = WINDOW_FRAC_BITS;
  localparam int WI_W  = $clog2(MAX_WINDOW) + 1;
  localparam int CW_W  = WI_W + F;
  localparam int CMP_W = (WI_W > CNT_W) ? WI_W : CNT_W;
  localparam int DC_W  = $clog2(F + 1);
  localparam logic [CW_W-1:0] CW_ONE   = CW_W'(1) << F;
  localparam logic [CW_W-1:0] CW_CAP   = CW_W'(MAX_WINDOW) << F;
  localparam logic [CW_W-1:0] REM_INIT = CW_W'(1) << (F - 1);
  localparam logic [DC_W-1:0] DC_INIT  = DC_W'(F);

  // configuration
  logic [MS_W-1:0]  cfg_min_to_r, cfg_min_to_nxt;
  logic [DUP_W-1:0] cfg_dup_thr_r, cfg_dup_thr_nxt;

  // protocol state
  logic [CW_W-1:0]   cwnd_r, cwnd_nxt;
  logic [CNT_W-1:0]  thr_r, thr_nxt;
  logic              ss_r, ss_nxt;
  logic              smp_en_r, smp_en_nxt;
  logic [RTTQ_W-1:0] est_r, est_nxt;
  logic [RTTQ_W-1:0] dev_r, dev_nxt;
  logic [DUP_W-1:0]  dup_r, dup_nxt;
  logic [CNT_W-1:0]  flt_r, flt_nxt;
  logic              tmr_r, tmr_nxt;

  // per-request working registers
  logic [ACT_W-1:0]    act_r, act_nxt;
  logic [SEQ_W-1:0]    ack_r, ack_nxt;
  logic [SEQ_W-1:0]    exp_r, exp_nxt;
  logic [CNT_W-1:0]    cov_r, cov_nxt;
  logic [MS_W-1:0]     smp_r, smp_nxt;
  logic                rtx_r, rtx_nxt;
  logic [RTTQ_W+1:0]   dev3_r, dev3_nxt;
  logic [CW_W-1:0]     rem_r, rem_nxt;
  logic [F:0]          quo_r, quo_nxt;
  logic [DC_W-1:0]     dcnt_r, dcnt_nxt;
  tcc_result_t         res_r, res_nxt;

  // combinational terms
  logic [CW_W:0]     ss_sum, ca_sum, div_sh, div_sub;
  logic [CW_W-1:0]   ss_win, ca_win;
  logic              div_ge;
  logic [CMP_W-1:0]  half_ext, win_ext, ss_win_ext;
  logic [CNT_W-1:0]  thr_collapse, win_out, cov_eff, flt_dec;
  logic [DUP_W-1:0]  dup_inc;
  logic [RTTQ_W-1:0] smp_q, est_dbl, diff;
  logic [RTTQ_W+3:0] est_sum;
  logic [RTTQ_W+1:0] dev_sum;
  logic [RTTQ_W+2:0] rto_sum;
  logic [MS_W-1:0]   rto_sat, rto_out;

  always_comb begin
    ss_sum     = {1'b0, cwnd_r} + {1'b0, CW_ONE};
    ss_win     = (ss_sum > {1'b0, CW_CAP}) ? CW_CAP : ss_sum[CW_W-1:0];
    ss_win_ext = CMP_W'(ss_win[CW_W-1:F]);
    ca_sum     = {1'b0, cwnd_r} + (CW_W+1)'(quo_r);
    ca_win     = (ca_sum > {1'b0, CW_CAP}) ? CW_CAP : ca_sum[CW_W-1:0];

    div_sh  = {rem_r, 1'b0};
    div_ge  = (div_sh >= {1'b0, cwnd_r});
    div_sub = div_sh - {1'b0, cwnd_r};

    half_ext = CMP_W'(cwnd_r[CW_W-1:F+1]);
    if (half_ext < CMP_W'(THR_MIN)) thr_collapse = THR_MIN;
    else if (half_ext > CMP_W'(CNT_MAX)) thr_collapse = CNT_MAX;
    else thr_collapse = half_ext[CNT_W-1:0];

    win_ext = CMP_W'(cwnd_r[CW_W-1:F]);
    win_out = (win_ext > CMP_W'(CNT_MAX)) ? CNT_MAX : win_ext[CNT_W-1:0];

    cov_eff = (cov_r == '0) ? CNT_W'(1) : cov_r;
    flt_dec = (flt_r > cov_eff) ? (flt_r - cov_eff) : '0;
    dup_inc = (dup_r == DUP_MAX) ? DUP_MAX : (dup_r + DUP_W'(1));

    smp_q   = {smp_r, 8'b0};
    est_sum = {1'b0, est_r, 3'b0} - (RTTQ_W+4)'(est_r) + (RTTQ_W+4)'(smp_q)
              + (RTTQ_W+4)'(4);
    diff    = (smp_q >= est_r) ? (smp_q - est_r) : (est_r - smp_q);
    dev_sum = dev3_r + (RTTQ_W+2)'(diff) + (RTTQ_W+2)'(2);
    est_dbl = (est_r > RTTQ_HALF) ? RTTQ_MAX : {est_r[RTTQ_W-2:0], 1'b0};

    rto_sum = (RTTQ_W+3)'(est_r) + (RTTQ_W+3)'({dev_r, 2'b00});
    rto_sat = (rto_sum[RTTQ_W+2:8] > (RTTQ_W-5)'(MS_MAX)) ? MS_MAX
                                                           : rto_sum[MS_W+7:8];
    rto_out = (rto_sat < cfg_min_to_r) ? cfg_min_to_r : rto_sat;
  end

  always_comb begin
    cfg_min_to_nxt   = cfg_min_to_r;
    cfg_dup_thr_nxt  = cfg_dup_thr_r;
    cwnd_nxt   = cwnd_r;
    thr_nxt    = thr_r;
    ss_nxt     = ss_r;
    smp_en_nxt = smp_en_r;
    est_nxt    = est_r;
    dev_nxt    = dev_r;
    dup_nxt    = dup_r;
    flt_nxt    = flt_r;
    tmr_nxt    = tmr_r;
    act_nxt    = act_r;
    ack_nxt    = ack_r;
    exp_nxt    = exp_r;
    cov_nxt    = cov_r;
    smp_nxt    = smp_r;
    rtx_nxt    = rtx_r;
    dev3_nxt   = dev3_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dcnt_nxt   = dcnt_r;
    res_nxt    = res_r;

    // start-up values load the matching state directly
    if (cfg_we) begin
      case (cfg_idx)
        CFG_INIT_SSTHRESH: thr_nxt = cfg_data[CNT_W-1:0];
        CFG_MIN_TIMEOUT: cfg_min_to_nxt = cfg_data;
        CFG_DUP_THRESHOLD: cfg_dup_thr_nxt = cfg_data[DUP_W-1:0];
        CFG_INIT_RTT: est_nxt = {cfg_data, 8'b0};
        CFG_INIT_DEV: dev_nxt = {cfg_data, 8'b0};
        default: ;
      endcase
    end

    if (cmd.load_in) begin
      act_nxt = in_action;
      ack_nxt = in_ack_number;
      exp_nxt = in_expected_ack;
      cov_nxt = in_segments_covered;
      smp_nxt = in_sample_rtt_ms;
      rtx_nxt = 1'b0;
    end

    if (cmd.do_send) begin
      if (flt_r != CNT_MAX) flt_nxt = flt_r + CNT_W'(1);
    end

    if (cmd.do_ack) begin
      smp_en_nxt = 1'b1;
      flt_nxt    = flt_dec;
      dup_nxt    = '0;
      tmr_nxt    = 1'b1;
      rem_nxt    = REM_INIT;
      quo_nxt    = '0;
      dcnt_nxt   = DC_INIT;
    end

    if (cmd.do_dup) begin
      dup_nxt = dup_inc;
      tmr_nxt = 1'b0;
      if (dup_inc >= cfg_dup_thr_r) begin
        rtx_nxt    = 1'b1;
        dup_nxt    = '0;
        tmr_nxt    = 1'b1;
        thr_nxt    = thr_collapse;
        cwnd_nxt   = CW_ONE;
        ss_nxt     = 1'b1;
        smp_en_nxt = 1'b0;
      end
    end

    if (cmd.do_timeout) begin
      rtx_nxt    = 1'b1;
      tmr_nxt    = 1'b1;
      thr_nxt    = thr_collapse;
      cwnd_nxt   = CW_ONE;
      ss_nxt     = 1'b1;
      smp_en_nxt = 1'b0;
      est_nxt    = est_dbl;
    end

    if (cmd.smp_est) begin
      est_nxt  = est_sum[RTTQ_W+2:3];
      dev3_nxt = {1'b0, dev_r, 1'b0} + (RTTQ_W+2)'(dev_r);
    end

    if (cmd.smp_dev) dev_nxt = dev_sum[RTTQ_W+1:2];

    if (cmd.ss_grow) begin
      cwnd_nxt = ss_win;
      if (ss_win_ext >= CMP_W'(thr_r)) ss_nxt = 1'b0;
    end

    // one quotient bit of 2^(2F) / cwnd per step
    if (cmd.div_step) begin
      rem_nxt  = div_ge ? div_sub[CW_W-1:0] : div_sh[CW_W-1:0];
      quo_nxt  = {quo_r[F-1:0], div_ge};
      dcnt_nxt = dcnt_r - DC_W'(1);
    end

    if (cmd.ca_add) cwnd_nxt = ca_win;

    if (cmd.out_load) begin
      res_nxt.window_packets    = win_out;
      res_nxt.threshold_packets = thr_r;
      res_nxt.timeout_ms        = rto_out;
      res_nxt.retransmit        = rtx_r;
      res_nxt.timer_restart     = (act_r == ACT_NONE) ? 1'b0 : tmr_r;
      res_nxt.send_allowed      = (CMP_W'(flt_r) < win_ext);
      res_nxt.in_slow_start     = ss_r;
      res_nxt.in_flight_count   = flt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_min_to_r   <= RST_MIN_TIMEOUT;
      cfg_dup_thr_r  <= RST_DUP_THR;
      cwnd_r   <= CW_ONE;
      thr_r    <= RST_SSTHRESH;
      ss_r     <= 1'b1;
      smp_en_r <= 1'b1;
      est_r    <= {RST_RTT, 8'b0};
      dev_r    <= {RST_DEV, 8'b0};
      dup_r    <= '0;
      flt_r    <= '0;
      tmr_r    <= 1'b1;
    end else begin
      cfg_min_to_r   <= cfg_min_to_nxt;
      cfg_dup_thr_r  <= cfg_dup_thr_nxt;
      cwnd_r   <= cwnd_nxt;
      thr_r    <= thr_nxt;
      ss_r     <= ss_nxt;
      smp_en_r <= smp_en_nxt;
      est_r    <= est_nxt;
      dev_r    <= dev_nxt;
      dup_r    <= dup_nxt;
      flt_r    <= flt_nxt;
      tmr_r    <= tmr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    ack_r  <= ack_nxt;
    exp_r  <= exp_nxt;
    cov_r  <= cov_nxt;
    smp_r  <= smp_nxt;
    rtx_r  <= rtx_nxt;
    dev3_r <= dev3_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dcnt_r <= dcnt_nxt;
    res_r  <= res_nxt;
  end

  assign sts.action     = act_r;
  assign sts.new_ack    = (ack_r >= exp_r);
  assign sts.sample_en  = smp_en_r;
  assign sts.slow_start = ss_r;
  assign sts.div_last   = (dcnt_r == '0);
  assign result         = res_r;

endmodule

[hw/rtl/tcc_congestion_window_control_core.sv]
// Top level of the sender-side congestion window controller.
`timescale 1ns / 1ps
// Usage
//   in_ch  : one request per event (segment sent, ACK received, timer expired).
//            A request is taken when valid and ready are high at a clock edge.
//   out_ch : one result per request, in order: window, threshold, timeout and
//            the retransmit, timer restart, send and slow start flags.
//   cfg_ch : register writes, always ready. Write only while no request is in
//            progress; writing a start-up value also reloads that state.
// Processing steps
//   Send, duplicate ACK, timeout and unused codes go from decode straight to
//   finish, where the result register is loaded. A new ACK first takes an RTT
//   sample (estimate, then deviation) when sampling is enabled, then grows
//   the window in slow start, or in congestion avoidance runs the bit-serial
//   divider for 1/cwnd and adds the quotient to the window. One request is
//   worked on at a time; the next is taken once the result is registered.
// Reset and stalls
//   rst_n (synchronous) loads the register defaults and the start-up state.
//   The result register holds while out_ch.ready is low; the next request is
//   still taken and processed, then waits until the register drains.
module tcp_congestion_window_control_core
  import tcc_pkg::*;
#(
  parameter int MAX_WINDOW       = 1024,
  parameter int WINDOW_FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tcc_in_if.sink    in_ch,
  tcc_out_if.source out_ch,
  tcc_cfg_if.sink   cfg_ch
);

  tcc_cmd_t    cmd;
  tcc_sts_t    sts;
  tcc_result_t result;

  // configuration writes load their registers directly
  assign cfg_ch.ready = 1'b1;

  tcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcc_dp #(
    .MAX_WINDOW       (MAX_WINDOW),
    .WINDOW_FRAC_BITS (WINDOW_FRAC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_ch.valid),
    .cfg_idx             (cfg_ch.index),
    .cfg_data            (cfg_ch.data),
    .in_action           (in_ch.action),
    .in_ack_number       (in_ch.ack_number),
    .in_expected_ack     (in_ch.expected_ack),
    .in_segments_covered (in_ch.segments_covered),
    .in_sample_rtt_ms    (in_ch.sample_rtt_ms),
    .result              (result)
  );

  // drive the result channel from the result register
  assign out_ch.window_packets    = result.window_packets;
  assign out_ch.threshold_packets = result.threshold_packets;
  assign out_ch.timeout_ms        = result.timeout_ms;
  assign out_ch.retransmit        = result.retransmit;
  assign out_ch.timer_restart     = result.timer_restart;
  assign out_ch.send_allowed      = result.send_allowed;
  assign out_ch.in_slow_start     = result.in_slow_start;
  assign out_ch.in_flight_count   = result.in_flight_count;

endmodule
